FILE: rtl/amb_pkg.sv
// amb_pkg: shared widths, request codes and register indexes of the
// approximate match scanner; no dependencies
`timescale 1ns / 1ps

package amb_pkg;

    // transaction field widths
    localparam int REQ_TYPE_W  = 2;
    localparam int BYTE_W      = 8;
    localparam int PIDX_W      = 6;
    localparam int OFFSET_W    = 32;

    // configuration register widths and port shape
    localparam int PLEN_W      = 7;
    localparam int MAXERR_W    = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;

    // error budget as used inside, wide enough for any layer count
    localparam int K_W         = 4;

    // one mask per byte value
    localparam int BYTE_VALUES = 256;

    // request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR   = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_PATTERN = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_TEXT    = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_BUDGET     = 1'd1;

endpackage

FILE: rtl/amb_req_if.sv
// amb_req_if: request channel of the approximate match scanner
// depends on amb_pkg
`timescale 1ns / 1ps

interface amb_req_if import amb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [BYTE_W-1:0]     item_byte;
    logic [PIDX_W-1:0]     pattern_index;
    logic                  end_of_text;

    modport source (
        output valid, req_type, item_byte, pattern_index, end_of_text,
        input  ready
    );
    modport sink (
        input  valid, req_type, item_byte, pattern_index, end_of_text,
        output ready
    );
endinterface

FILE: rtl/amb_res_if.sv
// amb_res_if: match result channel of the approximate match scanner
// depends on amb_pkg
`timescale 1ns / 1ps

interface amb_res_if import amb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] match_start;
    logic [OFFSET_W-1:0] match_end;

    modport source (
        output valid, match_start, match_end,
        input  ready
    );
    modport sink (
        input  valid, match_start, match_end,
        output ready
    );
endinterface

FILE: rtl/amb_mask_table.sv
// amb_mask_table: 256-entry byte mask memory with per-entry valid bits
// depends on amb_pkg
`timescale 1ns / 1ps

module amb_mask_table import amb_pkg::*; #(
    parameter int PATTERN_MAX = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_clear,
    input  logic                   i_wr_en,
    input  logic [BYTE_W-1:0]      i_wr_addr,
    input  logic [PIDX_W-1:0]      i_wr_idx,
    input  logic                   i_rd_en,
    input  logic [BYTE_W-1:0]      i_rd_addr,
    output logic [PATTERN_MAX-1:0] o_rd_mask
);

    logic [PATTERN_MAX-1:0] r_mem [BYTE_VALUES];
    logic [BYTE_VALUES-1:0] r_valid;
    logic [PATTERN_MAX-1:0] r_rd_data;
    logic                   r_rd_valid;
    logic [PATTERN_MAX-1:0] wr_bits;

    assign wr_bits = PATTERN_MAX'(64'(1) << i_wr_idx);

    // bit-enable write on a live entry, full overwrite on a stale one
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            if (r_valid[i_wr_addr]) begin
                for (int j = 0; j < PATTERN_MAX; j++) begin
                    if (wr_bits[j]) begin
                        r_mem[i_wr_addr][j] <= 1'b1;
                    end
                end
            end else begin
                r_mem[i_wr_addr] <= wr_bits;
            end
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_mask = r_rd_valid ? r_rd_data : '0;

endmodule

FILE: rtl/amb_layer_step.sv
// amb_layer_step: one text byte of the k-error bitap recurrence over all layers
// depends on amb_pkg
`timescale 1ns / 1ps

module amb_layer_step import amb_pkg::*; #(
    parameter int PATTERN_MAX = 64,
    parameter int ERRORS_MAX  = 5
) (
    input  logic [ERRORS_MAX:0][PATTERN_MAX-1:0] i_prev,
    input  logic [PATTERN_MAX-1:0]               i_dmask,
    input  logic [K_W-1:0]                       i_k,
    output logic [ERRORS_MAX:0][PATTERN_MAX-1:0] o_next
);

    localparam logic [PATTERN_MAX-1:0] ONE = PATTERN_MAX'(1);

    always_comb begin
        o_next[0] = ((i_prev[0] << 1) | ONE) & i_dmask;
        for (int d = 1; d <= ERRORS_MAX; d++) begin
            if (K_W'(d) <= i_k) begin
                // match, substitution, insertion, deletion, free leading errors
                o_next[d] = (((i_prev[d] << 1) | ONE) & i_dmask)
                          | i_prev[d-1]
                          | (i_prev[d-1] << 1)
                          | (o_next[d-1] << 1)
                          | PATTERN_MAX'((64'(1) << d) - 64'(1));
            end else begin
                o_next[d] = i_prev[d];
            end
        end
    end

endmodule

FILE: rtl/approx_match_bitap.sv
// approx_match_bitap: top level of the k-error bitap text scanner
// depends on amb_pkg, amb_req_if, amb_res_if, amb_mask_table, amb_layer_step
`timescale 1ns / 1ps
//
// usage
// - i_req carries clear, pattern byte and text byte transactions; o_res
//   carries one match transaction (start and end offset) per matching text byte
// - the pattern length and the error budget are written through i_cfg_we /
//   i_cfg_index / i_cfg_wdata while the block is idle; they take effect on
//   the next byte
// - a pattern byte is stored at its accept edge; the byte mask of a text byte
//   is read from the mask memory at its accept edge (registered read)
// - from the lookup stage the layer update, match test and offset arithmetic run in
//   one pass and land in the output register that drives o_res.valid; the lookup
//   stage waits while a pending result has not been taken
// - throughput is one transaction per cycle while the receiver takes results; the
//   mask memory read port and the layer update each take one transaction a cycle
// - when the receiver stalls with a result pending, the stage in front holds
//   and i_req.ready drops only once that stage is full too
// - reset empties the mask table (per-entry valid bits), the error layers,
//   the text position and both config registers; no clearing pass is needed
//
module approx_match_bitap import amb_pkg::*; #(
    parameter int PATTERN_MAX   = 64,
    parameter int ERRORS_MAX    = 5,
    parameter int POSITION_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    amb_req_if.sink               i_req,
    amb_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam logic [PLEN_W-1:0] PMAX_L  = PLEN_W'(PATTERN_MAX);
    localparam logic [K_W-1:0]    EMAX_L  = K_W'(ERRORS_MAX);
    localparam int                EXT_W   = POSITION_BITS + 1;
    localparam bit                POS_WRAP = (POSITION_BITS >= 64);

    // configuration
    logic [PLEN_W-1:0]   r_pattern_length;
    logic [MAXERR_W-1:0] r_err_budget;

    // lookup stage (mask read in flight)
    logic                  r_s1_valid;
    logic [REQ_TYPE_W-1:0] r_s1_type;
    logic                  r_s1_eot;

    // scan state
    logic [ERRORS_MAX:0][PATTERN_MAX-1:0] r_layers, n_layers;
    logic [POSITION_BITS-1:0]             r_pos, n_pos;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [OFFSET_W-1:0] r_out_start, n_out_start;
    logic [OFFSET_W-1:0] r_out_end, n_out_end;

    // handshake
    logic in_fire, out_free, s1_fire;

    // datapath
    logic [PATTERN_MAX-1:0]               dmask;
    logic [ERRORS_MAX:0][PATTERN_MAX-1:0] step_layers;
    logic [PLEN_W-1:0]                    m_eff;
    logic [K_W-1:0]                       k_eff;
    logic [PATTERN_MAX-1:0]               top_layer;
    logic [PATTERN_MAX-1:0]               top_shift;
    logic                                 hit;
    logic [EXT_W-1:0]                     end_plus1, end_plus1_c, m_ext, start_full;

    assign in_fire     = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign s1_fire     = r_s1_valid && out_free;
    assign i_req.ready = !r_s1_valid || out_free;

    // config writes, to be made only while idle; the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= '0;
            r_err_budget     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg_wdata;
                CFG_ERR_BUDGET:     r_err_budget     <= i_cfg_wdata[MAXERR_W-1:0];
                default:            ;
            endcase
        end
    end

    // mask memory: clear and pattern writes at accept, text reads at accept
    amb_mask_table #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_mask_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (in_fire && (i_req.req_type == REQ_CLEAR)),
        .i_wr_en   (in_fire && (i_req.req_type == REQ_PATTERN)
                    && ({1'b0, i_req.pattern_index} < PMAX_L)),
        .i_wr_addr (i_req.item_byte),
        .i_wr_idx  (i_req.pattern_index),
        .i_rd_en   (in_fire && (i_req.req_type == REQ_TEXT)),
        .i_rd_addr (i_req.item_byte),
        .o_rd_mask (dmask)
    );

    // lookup stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_type <= i_req.req_type;
            r_s1_eot  <= i_req.end_of_text;
        end
    end

    // clamp the registers to what the hardware holds
    assign m_eff = (r_pattern_length > PMAX_L) ? PMAX_L : r_pattern_length;
    assign k_eff = ({1'b0, r_err_budget} > EMAX_L) ? EMAX_L : {1'b0, r_err_budget};

    amb_layer_step #(
        .PATTERN_MAX (PATTERN_MAX),
        .ERRORS_MAX  (ERRORS_MAX)
    ) u_layer_step (
        .i_prev  (r_layers),
        .i_dmask (dmask),
        .i_k     (k_eff),
        .o_next  (step_layers)
    );

    // pick the layer of the error budget
    always_comb begin
        top_layer = '0;
        for (int d = 0; d <= ERRORS_MAX; d++) begin
            if (K_W'(d) == k_eff) begin
                top_layer = step_layers[d];
            end
        end
    end

    assign top_shift = top_layer >> (m_eff - PLEN_W'(1));
    assign hit       = (m_eff != '0) && top_shift[0];

    // start = end + 1 - m, clamped at zero; end + 1 wraps only when POSITION_BITS >= 64
    assign end_plus1   = {1'b0, r_pos} + EXT_W'(1);
    assign end_plus1_c = POS_WRAP ? {1'b0, end_plus1[POSITION_BITS-1:0]} : end_plus1;
    assign m_ext       = EXT_W'(m_eff);
    assign start_full  = (end_plus1_c >= m_ext) ? (end_plus1_c - m_ext) : '0;

    always_comb begin
        n_layers    = r_layers;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_start = r_out_start;
        n_out_end   = r_out_end;
        if (s1_fire) begin
            case (r_s1_type)
                REQ_CLEAR: begin
                    n_layers = '0;
                    n_pos    = '0;
                end
                REQ_TEXT: begin
                    n_layers = step_layers;
                    if (hit) begin
                        n_out_valid = 1'b1;
                        n_out_start = OFFSET_W'(start_full);
                        n_out_end   = OFFSET_W'(r_pos);
                    end
                    // saturating position
                    if (r_pos != '1) begin
                        n_pos = r_pos + POSITION_BITS'(1);
                    end
                    if (r_s1_eot) begin
                        n_layers = '0;
                        n_pos    = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layers    <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_layers    <= n_layers;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_start <= n_out_start;
        r_out_end   <= n_out_end;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.match_start = r_out_start;
    assign o_res.match_end   = r_out_end;

endmodule
